[sv/hss_pkg.sv]
// Shared constants and types of the Hermite segment sampler.
`default_nettype none

package hss_pkg;

    localparam int COORD_W    = 32;
    localparam int N_W        = 6;
    localparam int T_FRAC     = 16;
    localparam int T_W        = T_FRAC + 1;
    localparam int T2_W       = 2 * T_FRAC + 1;
    localparam int T3_W       = 3 * T_FRAC + 1;
    localparam int T3_SPLIT   = 24;
    localparam int A_W        = COORD_W + 3;
    localparam int B_W        = COORD_W + 4;
    localparam int SUM_W      = 86;
    localparam int ROUND_POS  = 3 * T_FRAC;
    localparam int PIPE_DEPTH = 7;
    localparam int DIV_STEPS  = T_W;
    localparam int CNT_W      = 5;

    localparam logic [T_W-1:0] T_ONE       = {1'b1, {T_FRAC{1'b0}}};
    localparam logic [N_W-1:0] STEPS_RESET = 6'd20;
    localparam logic [T_W-1:0] STEP_Q_RESET = T_W'((32'd1 << T_FRAC) / STEPS_RESET);
    localparam logic [N_W-1:0] STEP_R_RESET = N_W'((32'd1 << T_FRAC) % STEPS_RESET);

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [A_W-1:0]     a;
        logic signed [B_W-1:0]     b;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] d;
    } t_coef;

    typedef struct packed {
        logic [T_W-1:0] u;
        logic           last;
        t_coef          cx;
        t_coef          cy;
    } t_samp;

    typedef struct packed {
        logic           busy;
        logic [T_W-1:0] quo;
        logic [N_W-1:0] rem;
    } t_step;

endpackage

`default_nettype wire

[sv/hss_ifs.sv]
// Handshake interfaces for the segment, sample and configuration channels.
`default_nettype none

interface hss_seg_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [hss_pkg::COORD_W-1:0]   start_x;
    logic signed [hss_pkg::COORD_W-1:0]   start_y;
    logic signed [hss_pkg::COORD_W-1:0]   start_slope_x;
    logic signed [hss_pkg::COORD_W-1:0]   start_slope_y;
    logic signed [hss_pkg::COORD_W-1:0]   end_x;
    logic signed [hss_pkg::COORD_W-1:0]   end_y;
    logic signed [hss_pkg::COORD_W-1:0]   end_slope_x;
    logic signed [hss_pkg::COORD_W-1:0]   end_slope_y;

    modport source (
        output valid, start_x, start_y, start_slope_x, start_slope_y,
               end_x, end_y, end_slope_x, end_slope_y,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_slope_x, start_slope_y,
               end_x, end_y, end_slope_x, end_slope_y,
        output ready
    );
endinterface

interface hss_pt_if;
    logic                               valid;
    logic                               ready;
    logic signed [hss_pkg::COORD_W-1:0] sample_x;
    logic signed [hss_pkg::COORD_W-1:0] sample_y;
    logic                               last_sample;

    modport source (output valid, sample_x, sample_y, last_sample, input ready);
    modport sink (input valid, sample_x, sample_y, last_sample, output ready);
endinterface

interface hss_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [hss_pkg::N_W-1:0]    steps_per_segment;

    modport source (output valid, steps_per_segment, input ready);
    modport sink (input valid, steps_per_segment, output ready);
endinterface

`default_nettype wire

[sv/hss_step_div.sv]
// Bit-serial divider that finds the parameter increment 2^16 / N after a step count write.
`default_nettype none

module hss_step_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [hss_pkg::N_W-1:0] i_divisor,
    output hss_pkg::t_step          o_step
);

    localparam int NW = hss_pkg::N_W;
    localparam int TW = hss_pkg::T_W;
    localparam int CW = hss_pkg::CNT_W;

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [TW-1:0] r_quo;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_dvs;

    logic [NW:0]   w_part;
    logic [NW:0]   w_diff;
    logic          w_ge;

    assign w_part = {r_rem, r_quo[TW-1]};
    assign w_ge   = w_part >= {1'b0, r_dvs};
    assign w_diff = w_part - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_quo  <= hss_pkg::STEP_Q_RESET;
            r_rem  <= hss_pkg::STEP_R_RESET;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(hss_pkg::DIV_STEPS - 1);
            r_quo  <= hss_pkg::T_ONE;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[TW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[NW-1:0] : w_part[NW-1:0];
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_step = '{busy: r_busy, quo: r_quo, rem: r_rem};

endmodule

`default_nettype wire

[sv/hss_seq.sv]
// Segment sequencer: polynomial coefficients and the sample parameter for each point.
`default_nettype none

module hss_seq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [hss_pkg::N_W-1:0] i_steps,
    input  hss_pkg::t_step          i_step,
    input  logic                    i_en,
    hss_seg_if.sink                 i_seg,
    output logic                    o_vld,
    output hss_pkg::t_samp          o_samp
);

    localparam int NW = hss_pkg::N_W;
    localparam int TW = hss_pkg::T_W;
    localparam int AW = hss_pkg::A_W;
    localparam int BW = hss_pkg::B_W;
    localparam int RW = NW + 1;

    function automatic hss_pkg::t_coef coef_of(
        input logic signed [hss_pkg::COORD_W-1:0] p0,
        input logic signed [hss_pkg::COORD_W-1:0] d0,
        input logic signed [hss_pkg::COORD_W-1:0] p1,
        input logic signed [hss_pkg::COORD_W-1:0] d1
    );
        hss_pkg::t_coef    res;
        logic signed [BW-1:0] dp;
        logic signed [BW-1:0] ad;
        dp    = BW'(p1) - BW'(p0);
        ad    = BW'(d0) + BW'(d1) - (dp <<< 1);
        res.a = AW'(ad);
        res.b = (dp <<< 1) + dp - (BW'(d0) <<< 1) - BW'(d1);
        res.c = d0;
        res.d = p0;
        return res;
    endfunction

    logic           r_active;
    hss_pkg::t_coef r_cx;
    hss_pkg::t_coef r_cy;
    logic [NW-1:0]  r_n;
    logic [NW-1:0]  r_i;
    logic [TW-1:0]  r_q;
    logic [TW-1:0]  r_qstep;
    logic [NW-1:0]  r_rstep;
    logic [RW-1:0]  r_rem;

    logic           w_last;
    logic           w_take;
    logic [RW:0]    w_rsum;
    logic [RW:0]    w_two_n;
    logic           w_wrap;

    assign w_last  = r_i == r_n;
    assign w_rsum  = {1'b0, r_rem} + {1'b0, r_rstep, 1'b0};
    assign w_two_n = {1'b0, r_n, 1'b0};
    assign w_wrap  = w_rsum >= w_two_n;

    assign i_seg.ready = !i_step.busy && (!r_active || (i_en && w_last));
    assign w_take      = i_seg.valid && i_seg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (w_take) begin
            r_active <= 1'b1;
        end else if (i_en && w_last) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cx    <= coef_of(i_seg.start_x, i_seg.start_slope_x,
                               i_seg.end_x, i_seg.end_slope_x);
            r_cy    <= coef_of(i_seg.start_y, i_seg.start_slope_y,
                               i_seg.end_y, i_seg.end_slope_y);
            r_n     <= i_steps;
            r_qstep <= i_step.quo;
            r_rstep <= i_step.rem;
            r_q     <= '0;
            r_rem   <= {1'b0, i_steps};
            r_i     <= '0;
        end else if (r_active && i_en && !w_last) begin
            r_i   <= r_i + NW'(1);
            r_q   <= r_q + r_qstep + {{(TW-1){1'b0}}, w_wrap};
            r_rem <= w_wrap ? RW'(w_rsum - w_two_n) : RW'(w_rsum);
        end
    end

    assign o_vld  = r_active;
    assign o_samp = '{u: r_q, last: w_last, cx: r_cx, cy: r_cy};

endmodule

`default_nettype wire

[sv/hss_axis.sv]
// One coordinate axis: partial products, exact sum, rounding and saturation.
`default_nettype none

module hss_axis (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [hss_pkg::T_W-1:0]            i_u,
    input  logic [hss_pkg::T2_W-1:0]           i_t2,
    input  logic [hss_pkg::T3_W-1:0]           i_t3,
    input  hss_pkg::t_coef                     i_coef,
    output logic signed [hss_pkg::COORD_W-1:0] o_sample
);

    localparam int CW   = hss_pkg::COORD_W;
    localparam int TF   = hss_pkg::T_FRAC;
    localparam int TW   = hss_pkg::T_W;
    localparam int T2W  = hss_pkg::T2_W;
    localparam int T3W  = hss_pkg::T3_W;
    localparam int TS   = hss_pkg::T3_SPLIT;
    localparam int AW   = hss_pkg::A_W;
    localparam int BW   = hss_pkg::B_W;
    localparam int SW   = hss_pkg::SUM_W;
    localparam int RP   = hss_pkg::ROUND_POS;
    localparam int VW   = SW - RP;
    localparam int T3HW = T3W - TS;
    localparam int T2HW = T2W - TF;
    localparam int PAHW = AW + T3HW + 1;
    localparam int PALW = AW + TS + 1;
    localparam int PBHW = BW + T2HW + 1;
    localparam int PBLW = BW + TF + 1;
    localparam int PCW  = CW + TW + 1;

    localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (RP - 1);

    logic signed [AW-1:0]   w_a;
    logic signed [BW-1:0]   w_b;
    logic signed [CW-1:0]   w_c;
    logic signed [T3HW:0]   w_t3h;
    logic signed [TS:0]     w_t3l;
    logic signed [T2HW:0]   w_t2h;
    logic signed [TF:0]     w_t2l;
    logic signed [TW:0]     w_u;

    logic signed [PAHW-1:0] n_pa_h;
    logic signed [PALW-1:0] n_pa_l;
    logic signed [PBHW-1:0] n_pb_h;
    logic signed [PBLW-1:0] n_pb_l;
    logic signed [PCW-1:0]  n_pc;

    logic signed [PAHW-1:0] r_pa_h;
    logic signed [PALW-1:0] r_pa_l;
    logic signed [PBHW-1:0] r_pb_h;
    logic signed [PBLW-1:0] r_pb_l;
    logic signed [PCW-1:0]  r_pc;
    logic signed [CW-1:0]   r_d;

    logic signed [SW-1:0]   n_s1;
    logic signed [SW-1:0]   n_s2;
    logic signed [SW-1:0]   n_s3;
    logic signed [SW-1:0]   r_s1;
    logic signed [SW-1:0]   r_s2;
    logic signed [SW-1:0]   r_s3;
    logic signed [SW-1:0]   r_s12;
    logic signed [SW-1:0]   r_s3r;
    logic signed [SW-1:0]   r_tot;

    logic signed [VW-1:0]   w_v;
    logic                   w_fits;
    logic signed [CW-1:0]   n_out;
    logic signed [CW-1:0]   r_out;

    assign w_a   = i_coef.a;
    assign w_b   = i_coef.b;
    assign w_c   = i_coef.c;
    assign w_t3h = {1'b0, i_t3[T3W-1:TS]};
    assign w_t3l = {1'b0, i_t3[TS-1:0]};
    assign w_t2h = {1'b0, i_t2[T2W-1:TF]};
    assign w_t2l = {1'b0, i_t2[TF-1:0]};
    assign w_u   = {1'b0, i_u};

    assign n_pa_h = w_a * w_t3h;
    assign n_pa_l = w_a * w_t3l;
    assign n_pb_h = w_b * w_t2h;
    assign n_pb_l = w_b * w_t2l;
    assign n_pc   = w_c * w_u;

    assign n_s1 = (SW'(r_pa_h) <<< TS) + SW'(r_pa_l);
    assign n_s2 = (SW'(r_pb_h) <<< (2 * TF)) + (SW'(r_pb_l) <<< TF);
    assign n_s3 = (SW'(r_pc) <<< (2 * TF)) + (SW'(r_d) <<< RP);

    assign w_v    = r_tot[SW-1:RP];
    assign w_fits = (&w_v[VW-1:CW-1]) || !(|w_v[VW-1:CW-1]);
    assign n_out  = w_fits ? w_v[CW-1:0]
                           : (w_v[VW-1] ? hss_pkg::COORD_MIN : hss_pkg::COORD_MAX);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa_h <= n_pa_h;
            r_pa_l <= n_pa_l;
            r_pb_h <= n_pb_h;
            r_pb_l <= n_pb_l;
            r_pc   <= n_pc;
            r_d    <= i_coef.d;
            r_s1   <= n_s1;
            r_s2   <= n_s2;
            r_s3   <= n_s3;
            r_s12  <= r_s1 + r_s2;
            r_s3r  <= r_s3 + ROUND_HALF;
            r_tot  <= r_s12 + r_s3r;
            r_out  <= n_out;
        end
    end

    assign o_sample = r_out;

endmodule

`default_nettype wire

[sv/hss_pipe.sv]
// Evaluation pipeline: parameter powers, both axes and the output register.
`default_nettype none

module hss_pipe (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  hss_pkg::t_samp i_samp,
    output logic           o_en,
    hss_pt_if.source       o_pt
);

    localparam int D   = hss_pkg::PIPE_DEPTH;
    localparam int TW  = hss_pkg::T_W;
    localparam int T2W = hss_pkg::T2_W;
    localparam int T3W = hss_pkg::T3_W;

    logic [D-1:0]        r_vld;
    logic [D-1:0]        r_last;
    logic                w_en;

    logic [2*TW-1:0]     n_t2;
    logic [T2W+TW-1:0]   n_t3;

    logic [TW-1:0]       r_u1;
    logic [T2W-1:0]      r_t2_1;
    hss_pkg::t_coef      r_cx1;
    hss_pkg::t_coef      r_cy1;
    logic [TW-1:0]       r_u2;
    logic [T2W-1:0]      r_t2_2;
    logic [T3W-1:0]      r_t3_2;
    hss_pkg::t_coef      r_cx2;
    hss_pkg::t_coef      r_cy2;

    logic signed [hss_pkg::COORD_W-1:0] w_sx;
    logic signed [hss_pkg::COORD_W-1:0] w_sy;

    assign w_en = !r_vld[D-1] || o_pt.ready;
    assign n_t2 = i_samp.u * i_samp.u;
    assign n_t3 = r_t2_1 * r_u1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[D-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last <= {r_last[D-2:0], i_samp.last};
            r_u1   <= i_samp.u;
            r_t2_1 <= n_t2[T2W-1:0];
            r_cx1  <= i_samp.cx;
            r_cy1  <= i_samp.cy;
            r_u2   <= r_u1;
            r_t2_2 <= r_t2_1;
            r_t3_2 <= n_t3[T3W-1:0];
            r_cx2  <= r_cx1;
            r_cy2  <= r_cy1;
        end
    end

    hss_axis u_axis_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_u      (r_u2),
        .i_t2     (r_t2_2),
        .i_t3     (r_t3_2),
        .i_coef   (r_cx2),
        .o_sample (w_sx)
    );

    hss_axis u_axis_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_u      (r_u2),
        .i_t2     (r_t2_2),
        .i_t3     (r_t3_2),
        .i_coef   (r_cy2),
        .o_sample (w_sy)
    );

    assign o_en             = w_en;
    assign o_pt.valid       = r_vld[D-1];
    assign o_pt.last_sample = r_last[D-1];
    assign o_pt.sample_x    = w_sx;
    assign o_pt.sample_y    = w_sy;

endmodule

`default_nettype wire

[sv/hermite_segment_sampler.sv]
// Top level of the Hermite segment sampler.
`default_nettype none

// Each segment word gives two end points and their tangents; the block returns
// steps_per_segment + 1 sample words, one per cycle while the output is not stalled,
// and the next segment can be taken in the cycle that issues the previous segment's
// last sample. A write of zero to the step count is taken as one. The first sample
// passes through a seven-stage evaluation pipeline that a stalled output holds in
// place. After each step count write, a bit-serial divider runs, and no segment
// word is taken while it is busy.
module hermite_segment_sampler (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hss_cfg_if.sink  i_cfg,
    hss_seg_if.sink  i_seg,
    hss_pt_if.source o_pt
);

    localparam int NW = hss_pkg::N_W;

    logic [NW-1:0]   r_steps;
    logic            w_cfg_wr;
    logic [NW-1:0]   w_cfg_n;
    hss_pkg::t_step  w_step;
    logic            w_vld;
    logic            w_en;
    hss_pkg::t_samp  w_samp;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;
    assign w_cfg_n     = (i_cfg.steps_per_segment == '0) ? NW'(1) : i_cfg.steps_per_segment;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= hss_pkg::STEPS_RESET;
        end else if (w_cfg_wr) begin
            r_steps <= w_cfg_n;
        end
    end

    hss_step_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_cfg_wr),
        .i_divisor (w_cfg_n),
        .o_step    (w_step)
    );

    hss_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_steps (r_steps),
        .i_step  (w_step),
        .i_en    (w_en),
        .i_seg   (i_seg),
        .o_vld   (w_vld),
        .o_samp  (w_samp)
    );

    hss_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld),
        .i_samp  (w_samp),
        .o_en    (w_en),
        .o_pt    (o_pt)
    );

    a_no_take_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_seg.valid && i_seg.ready) |-> !w_step.busy)
        else $error("Segment word taken while the step divider is busy.");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld && w_en) |-> (w_samp.last == (w_samp.u == hss_pkg::T_ONE)))
        else $error("Last sample flag does not match the end of the segment.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pt.valid)
        else $error("Output word valid straight after reset.");

endmodule

`default_nettype wire

[verif/hermite_segment_sampler_tb.sv]
// Self-checking testbench of the Hermite segment sampler with exact point prediction.
`timescale 1ns / 1ps

module hermite_segment_sampler_tb;

    localparam int     CW           = hss_pkg::COORD_W;
    localparam int     NW           = hss_pkg::N_W;
    localparam int     TF           = hss_pkg::T_FRAC;
    localparam longint T_UNIT       = 64'd1 << TF;
    localparam longint H_ONE        = 64'd1 << (3 * TF);
    localparam int     HOLD_CYCLES  = 400;
    localparam int     REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_slope_x;
        logic signed [CW-1:0] start_slope_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_slope_x;
        logic signed [CW-1:0] end_slope_y;
    } t_segment;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
    } t_point;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hss_cfg_if cfg_if ();
    hss_seg_if seg_if ();
    hss_pt_if  pt_if ();

    hermite_segment_sampler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_seg   (seg_if),
        .o_pt    (pt_if)
    );

    t_segment      segments_to_send[$];
    t_point        expected_points[$];
    t_segment      next_seg;
    t_segment      seg_on_wire;
    t_point        want;
    logic [NW-1:0] steps_cfg = hss_pkg::STEPS_RESET;
    bit            seg_taken = 1'b0;
    bit            hold_request = 1'b0;
    int            hold_left = 0;
    int            segments_owed = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            errors = 0;

    always #2 i_clk = ~i_clk;

    // Rounds the exact blend once to the coordinate grid and saturates it.
    function automatic logic signed [CW-1:0] blend_axis(
        input logic signed [CW-1:0] p0, d0, p1, d1,
        input longint h00, h10, h01, h11
    );
        logic signed [127:0] acc;
        logic signed [127:0] pw;
        logic signed [127:0] hw;
        acc = '0;
        pw = p0; hw = h00; acc = acc + pw * hw;
        pw = d0; hw = h10; acc = acc + pw * hw;
        pw = p1; hw = h01; acc = acc + pw * hw;
        pw = d1; hw = h11; acc = acc + pw * hw;
        acc = (acc + (128'sd1 <<< (3 * TF - 1))) >>> (3 * TF);
        if (acc > 128'sd2147483647) begin
            return hss_pkg::COORD_MAX;
        end
        if (acc < -128'sd2147483648) begin
            return hss_pkg::COORD_MIN;
        end
        return acc[CW-1:0];
    endfunction

    function automatic void sample_segment(input t_segment s);
        longint n, i, t, t2, t3, t2s, ts;
        longint h00, h10, h01, h11;
        t_point p;
        n = (steps_cfg == 0) ? 1 : steps_cfg;
        for (i = 0; i <= n; i++) begin
            t   = (2 * i * T_UNIT + n) / (2 * n);
            t2  = t * t;
            t3  = t2 * t;
            t2s = t2 * T_UNIT;
            ts  = t * T_UNIT * T_UNIT;
            h00 = 2 * t3 - 3 * t2s + H_ONE;
            h10 = t3 - 2 * t2s + ts;
            h01 = -2 * t3 + 3 * t2s;
            h11 = t3 - t2s;
            p.x = blend_axis(s.start_x, s.start_slope_x, s.end_x, s.end_slope_x,
                             h00, h10, h01, h11);
            p.y = blend_axis(s.start_y, s.start_slope_y, s.end_y, s.end_slope_y,
                             h00, h10, h01, h11);
            p.last = (i == n);
            expected_points.push_back(p);
        end
    endfunction

    function automatic logic signed [CW-1:0] random_coord();
        case ($urandom_range(0, 4))
            0, 1: return $urandom;
            2: return $urandom_range(0, 1 << 20) - (1 << 19);
            3: return $signed($urandom) >>> $urandom_range(2, 24);
            default: begin
                case ($urandom_range(0, 3))
                    0: return hss_pkg::COORD_MAX;
                    1: return hss_pkg::COORD_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    task automatic queue_segment(input logic signed [CW-1:0] sx, sy, dsx, dsy,
                                 ex, ey, dex, dey);
        segments_to_send.push_back({sx, sy, dsx, dsy, ex, ey, dex, dey});
        segments_owed++;
    endtask

    task automatic drain();
        while (segments_owed != 0 || expected_points.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_steps(input logic [NW-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.steps_per_segment <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        steps_cfg = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [NW-1:0] steps, input int idle, input int stall,
                             input int count, input bit hold);
        int k;
        write_steps(steps);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (k = 0; k < count; k++) begin
            queue_segment(random_coord(), random_coord(), random_coord(), random_coord(),
                          random_coord(), random_coord(), random_coord(), random_coord());
        end
        if (hold) begin
            @(negedge i_clk);
            hold_request = 1'b1;
        end
        drain();
    endtask

    // Segment driver: a word stays on the bus until it has been taken.
    always @(negedge i_clk) begin
        if (!seg_if.valid || seg_taken) begin
            seg_taken = 1'b0;
            if (segments_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_seg = segments_to_send.pop_front();
                seg_on_wire = next_seg;
                seg_if.valid <= 1'b1;
                {seg_if.start_x, seg_if.start_y, seg_if.start_slope_x, seg_if.start_slope_y,
                 seg_if.end_x, seg_if.end_y, seg_if.end_slope_x, seg_if.end_slope_y}
                    <= next_seg;
            end else begin
                seg_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        pt_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left--;
        end
    end

    // Monitor: predicts on every segment word taken and checks every sample word.
    always @(posedge i_clk) begin
        if (seg_if.valid && seg_if.ready) begin
            sample_segment(seg_on_wire);
            seg_taken = 1'b1;
            segments_owed--;
        end
        if (pt_if.valid && pt_if.ready) begin
            if (expected_points.size() == 0) begin
                if (errors < REPORT_LIMIT) begin
                    $display("Unexpected sample word: x=%0d y=%0d last=%0b",
                             pt_if.sample_x, pt_if.sample_y, pt_if.last_sample);
                end
                errors++;
            end else begin
                want = expected_points.pop_front();
                if (pt_if.sample_x !== want.x || pt_if.sample_y !== want.y ||
                    pt_if.last_sample !== want.last) begin
                    if (errors < REPORT_LIMIT) begin
                        $display({"Sample mismatch: expected x=%0d y=%0d last=%0b, ",
                                  "got x=%0d y=%0d last=%0b"},
                                 want.x, want.y, want.last,
                                 pt_if.sample_x, pt_if.sample_y, pt_if.last_sample);
                    end
                    errors++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int r;
        int idle;
        int stall;
        i_rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.steps_per_segment = '0;
        seg_if.valid = 1'b0;
        {seg_if.start_x, seg_if.start_y, seg_if.start_slope_x, seg_if.start_slope_y,
         seg_if.end_x, seg_if.end_y, seg_if.end_slope_x, seg_if.end_slope_y} = '0;
        pt_if.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed segments at the reset step count, with saturation in both directions.
        queue_segment(0, 0, 0, 0, 0, 0, 0, 0);
        queue_segment(hss_pkg::COORD_MAX, hss_pkg::COORD_MAX,
                      hss_pkg::COORD_MAX, hss_pkg::COORD_MAX,
                      hss_pkg::COORD_MAX, hss_pkg::COORD_MAX,
                      hss_pkg::COORD_MAX, hss_pkg::COORD_MAX);
        queue_segment(hss_pkg::COORD_MIN, hss_pkg::COORD_MIN,
                      hss_pkg::COORD_MIN, hss_pkg::COORD_MIN,
                      hss_pkg::COORD_MIN, hss_pkg::COORD_MIN,
                      hss_pkg::COORD_MIN, hss_pkg::COORD_MIN);
        queue_segment(hss_pkg::COORD_MAX, hss_pkg::COORD_MIN,
                      hss_pkg::COORD_MAX, hss_pkg::COORD_MIN,
                      hss_pkg::COORD_MAX, hss_pkg::COORD_MIN,
                      hss_pkg::COORD_MIN, hss_pkg::COORD_MAX);
        queue_segment(hss_pkg::COORD_MIN, hss_pkg::COORD_MAX, 0, 0,
                      hss_pkg::COORD_MAX, hss_pkg::COORD_MIN, 0, 0);
        queue_segment(hss_pkg::COORD_MAX, hss_pkg::COORD_MIN,
                      hss_pkg::COORD_MAX, hss_pkg::COORD_MIN,
                      hss_pkg::COORD_MIN, hss_pkg::COORD_MAX,
                      hss_pkg::COORD_MAX, hss_pkg::COORD_MIN);
        queue_segment(0, 0, hss_pkg::COORD_MAX, hss_pkg::COORD_MIN,
                      0, 0, hss_pkg::COORD_MAX, hss_pkg::COORD_MIN);
        queue_segment(0, 0, hss_pkg::COORD_MIN, hss_pkg::COORD_MAX,
                      0, 0, hss_pkg::COORD_MAX, hss_pkg::COORD_MIN);
        queue_segment(1, -1, 2, -2, -1, 1, -2, 2);
        queue_segment(0, 0, 65536, 65536, 65536, 65536, 65536, 65536);
        queue_segment(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                      32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        queue_segment(-1, -1, -1, -1, -1, -1, -1, -1);
        drain();

        run_phase(6'd63, 0, 0, 20, 1'b0);
        run_phase(6'd0, 45, 0, 35, 1'b0);
        run_phase(6'd1, 0, 45, 35, 1'b1);
        run_phase(6'd7, 8, 8, 40, 1'b0);
        run_phase(6'd2, 0, 0, 30, 1'b0);
        run_phase(6'd63, 8, 8, 15, 1'b0);
        repeat (4) begin
            r = $urandom_range(0, 3);
            idle = (r == 1) ? 45 : (r == 3) ? 8 : 0;
            stall = (r == 2) ? 45 : (r == 3) ? 8 : 0;
            run_phase(NW'($urandom_range(3, 40)), idle, stall, 25, 1'b0);
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_points.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
